// ===== sv/tfd_pkg.sv =====
// ----------------------------------------------------------------------------
// tfd_pkg
// Shared types and constants of the telemetry frame deframer.
// ----------------------------------------------------------------------------
package tfd_pkg;

  localparam int unsigned WinLen   = 10;
  localparam int unsigned FillW    = $clog2(WinLen);
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned OutDataW = 72;
  localparam int unsigned DivNumW  = 25;
  localparam int unsigned DivDenW  = 16;
  localparam int unsigned DivCntW  = $clog2(DivNumW);
  localparam int unsigned QDepth   = 2;

  localparam logic [ByteW-1:0] SyncByte0 = 8'hAA;
  localparam logic [ByteW-1:0] SyncByte1 = 8'h55;
  localparam logic [ByteW-1:0] FrameLen  = 8'd6;

  localparam logic [CfgIdxW-1:0] CfgBattEmpty = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBattFull  = 2'd1;

  localparam logic [CfgDataW-1:0] BattEmptyRst = 16'd9900;
  localparam logic [CfgDataW-1:0] BattFullRst  = 16'd12600;

  // km/h in Q.8 = floor(|mm/s| * 576 / 625); over 0..32768 this equals
  // a multiply by ceil(2^25 * 576 / 625) and a right shift by 25
  localparam int unsigned         KmhShift  = 25;
  localparam logic [24:0]         KmhRecip  = 25'd30923765;
  localparam logic [6:0]          PctMul = 7'd100;
  localparam logic [6:0]          PctMax = 7'd100;

  typedef struct packed {
    logic [7:0]         fault;
    logic signed [7:0]  temp;
    logic [15:0]        volt;
    logic signed [15:0] speed;
  } frame_t;

  typedef struct packed {
    logic [7:0]         fault;
    logic signed [7:0]  temp;
    logic [6:0]         pct;
    logic [15:0]        volt;
    logic [14:0]        kmh;
    logic signed [15:0] speed;
  } result_t;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] num;
    logic [DivDenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DivNumW-1:0] quo;
  } div_rsp_t;

endpackage

// ===== sv/tfd_front.sv =====
// ----------------------------------------------------------------------------
// tfd_front
// Byte window: collects bytes, checks sync, length and checksum on the
// tenth byte, drops bytes on a failed check and pushes good frames.
// ----------------------------------------------------------------------------
module tfd_front import tfd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             q_full_i,
  output logic             push_o,
  output frame_t           frame_o
);

  logic [ByteW-1:0] win_q [WinLen-1];
  logic [ByteW-1:0] win_d [WinLen-1];
  logic [ByteW-1:0] fw    [WinLen];
  logic [FillW-1:0] fill_q, fill_d;
  logic [ByteW-1:0] sum;
  logic             acc, last, hdr_bad, len_bad, sum_bad;

  assign in_ready_o = !q_full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign last       = (fill_q == FillW'(WinLen - 1));

  always_comb begin
    for (int i = 0; i < WinLen - 1; i++) begin
      fw[i] = win_q[i];
    end
    fw[WinLen-1] = in_byte_i;
  end

  always_comb begin
    sum = '0;
    for (int i = 3; i < 9; i++) begin
      sum = sum ^ fw[i];
    end
  end

  assign hdr_bad = (fw[0] != SyncByte0) || (fw[1] != SyncByte1);
  assign len_bad = (fw[2] != FrameLen);
  assign sum_bad = (sum != fw[9]);

  always_comb begin
    win_d  = win_q;
    fill_d = fill_q;
    push_o = 1'b0;
    if (acc) begin
      if (!last) begin
        win_d[fill_q] = in_byte_i;
        fill_d        = fill_q + FillW'(1);
      end else if (hdr_bad) begin
        // drop one byte
        for (int i = 0; i < WinLen - 1; i++) begin
          win_d[i] = fw[i+1];
        end
        fill_d = FillW'(WinLen - 1);
      end else if (len_bad) begin
        // drop three bytes
        for (int i = 0; i < WinLen - 3; i++) begin
          win_d[i] = fw[i+3];
        end
        fill_d = FillW'(WinLen - 3);
      end else if (sum_bad) begin
        // drop two bytes
        for (int i = 0; i < WinLen - 2; i++) begin
          win_d[i] = fw[i+2];
        end
        fill_d = FillW'(WinLen - 2);
      end else begin
        push_o = 1'b1;
        fill_d = '0;
      end
    end
  end

  assign frame_o.speed = {fw[4], fw[3]};
  assign frame_o.volt  = {fw[6], fw[5]};
  assign frame_o.temp  = fw[7];
  assign frame_o.fault = fw[8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

// ===== sv/tfd_fifo.sv =====
// ----------------------------------------------------------------------------
// tfd_fifo
// Two-entry frame queue between the byte window and the decode engine.
// ----------------------------------------------------------------------------
module tfd_fifo import tfd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  frame_t push_data_i,
  output logic   full_o,
  output logic   valid_o,
  input  logic   pop_i,
  output frame_t pop_data_o
);

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  frame_t            mem_q [QDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(QDepth));
  assign valid_o    = (cnt_q != '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== sv/tfd_div.sv =====
// ----------------------------------------------------------------------------
// tfd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tfd_div import tfd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DivNumW-1:0] sh_q;
  logic [DivDenW-1:0] rem_q, den_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q, done_q;
  logic [DivDenW:0]   trial, diff;
  logic               ge;

  assign trial = {rem_q, sh_q[DivNumW-1]};
  assign ge    = (trial >= {1'b0, den_q});
  assign diff  = trial - {1'b0, den_q};

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = sh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DivCntW'(1);
        if (cnt_q == DivCntW'(DivNumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sh_q  <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DivDenW-1:0] : trial[DivDenW-1:0];
      sh_q  <= {sh_q[DivNumW-2:0], ge};
    end
  end

endmodule

// ===== sv/tfd_back.sv =====
// ----------------------------------------------------------------------------
// tfd_back
// Decode engine: takes frames from the queue, derives km/h by a reciprocal
// multiply and battery percent through the divider or as a fixed value, and
// holds the result for the output.
// ----------------------------------------------------------------------------
module tfd_back import tfd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  frame_t              q_data_i,
  output logic                q_pop_o,
  input  logic [CfgDataW-1:0] batt_empty_i,
  input  logic [CfgDataW-1:0] batt_full_i,
  output div_req_t            div_req_o,
  input  div_rsp_t            div_rsp_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output result_t             out_data_o
);

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StMul     = 3'd1;
  localparam logic [2:0] StPct     = 3'd4;
  localparam logic [2:0] StPctWait = 3'd5;
  localparam logic [2:0] StFin     = 3'd6;

  logic [2:0]          state_q, state_d;
  frame_t              frm_q;
  logic [DivNumW-1:0]  pct_num_q;
  logic [DivDenW-1:0]  pct_den_q;
  logic                pct_div_q;
  logic [6:0]          pct_q, pct_const_q;
  logic [14:0]         kmh_q;
  result_t             res_q;
  logic                out_valid_q;
  logic [16:0]         mag;
  logic [16+KmhShift:0] kmh_prod;
  logic [15:0]         mv_diff, span;
  logic                load_out;

  assign mag      = frm_q.speed[15] ? (17'h10000 - {1'b0, frm_q.speed})
                                    : {1'b0, frm_q.speed};
  assign kmh_prod = (17 + KmhShift)'(mag) * (17 + KmhShift)'(KmhRecip);
  assign mv_diff  = frm_q.volt - batt_empty_i;
  assign span     = batt_full_i - batt_empty_i;

  assign q_pop_o     = (state_q == StIdle) && q_valid_i;
  assign load_out    = (state_q == StFin) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  always_comb begin
    div_req_o = '{start: 1'b0, num: pct_num_q, den: pct_den_q};
    if (state_q == StPct) begin
      div_req_o.start = pct_div_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:    if (q_valid_i) state_d = StMul;
      StMul:     state_d = StPct;
      StPct:     state_d = pct_div_q ? StPctWait : StFin;
      StPctWait: if (div_rsp_i.done) state_d = StFin;
      StFin:     if (load_out) state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      frm_q <= q_data_i;
    end
    if (state_q == StMul) begin
      kmh_q     <= kmh_prod[KmhShift +: 15];
      pct_num_q <= DivNumW'(mv_diff) * DivNumW'(PctMul);
      pct_den_q <= span;
      pct_div_q <= 1'b0;
      // at or below empty, or an inverted span, reads as empty
      if (frm_q.volt <= batt_empty_i) begin
        pct_const_q <= '0;
      end else if (batt_full_i == batt_empty_i) begin
        pct_const_q <= PctMax;
      end else if (batt_full_i < batt_empty_i) begin
        pct_const_q <= '0;
      end else begin
        pct_const_q <= '0;
        pct_div_q   <= 1'b1;
      end
    end
    if (state_q == StPct && !pct_div_q) begin
      pct_q <= pct_const_q;
    end
    if (state_q == StPctWait && div_rsp_i.done) begin
      pct_q <= (div_rsp_i.quo > DivNumW'(PctMax)) ? PctMax : div_rsp_i.quo[6:0];
    end
    if (load_out) begin
      res_q.speed <= frm_q.speed;
      res_q.kmh   <= kmh_q;
      res_q.volt  <= frm_q.volt;
      res_q.pct   <= pct_q;
      res_q.temp  <= frm_q.temp;
      res_q.fault <= frm_q.fault;
    end
  end

endmodule

// ===== sv/telemetry_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// telemetry_frame_deframer
// Deframes AA 55 06 telemetry frames from a byte stream into decoded records.
// ----------------------------------------------------------------------------
// Input stream s_axis carries one received byte per item. Output stream
// m_axis carries one decoded record per good frame: speed, km/h in Q.8,
// voltage, battery percent, temperature and fault code. The cfg channel
// writes battery_empty_mv (index 0) and battery_full_mv (index 1); it is
// always ready and should be used while no frame is in flight.
// A byte is taken each cycle while the two-entry frame queue has room.
// The byte that completes a good frame pushes it into the queue at once.
// The decode engine holds one frame at a time and finds battery percent
// with the 25-step divider; km/h comes from a reciprocal multiply
// registered in StMul. A frame whose percent is fixed (at or below empty,
// zero or inverted span) skips the divider. A frame passes from the queue
// through StMul, StPct, StPctWait (divider only) and StFin to the output.
// Reset empties the byte window and the queue, drops any pending record
// and restores both battery thresholds. When the receiver stalls, the
// record holds in the output register, the engine waits, the queue fills,
// and s_axis_tready drops only once both queue entries are taken.
// ----------------------------------------------------------------------------
module telemetry_frame_deframer import tfd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] rx_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [15:0] speed_raw, [30:16] speed_kmh_q8, [46:31] voltage_mv,
  // [53:47] battery_percent, [61:54] temperature, [69:62] fault_code
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [CfgDataW-1:0] batt_empty_q, batt_full_q;
  logic                push, q_full, q_valid, q_pop;
  frame_t              push_frame, q_frame;
  div_req_t            div_req;
  div_rsp_t            div_rsp;
  result_t             result;

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {(OutDataW - $bits(result_t))'(0), result};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batt_empty_q <= BattEmptyRst;
      batt_full_q  <= BattFullRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgBattEmpty: batt_empty_q <= cfg_data_i;
        CfgBattFull:  batt_full_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .q_full_i   (q_full),
    .push_o     (push),
    .frame_o    (push_frame)
  );

  tfd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_frame),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (q_frame)
  );

  tfd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  tfd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_data_i     (q_frame),
    .q_pop_o      (q_pop),
    .batt_empty_i (batt_empty_q),
    .batt_full_i  (batt_full_q),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (result)
  );

endmodule

// ===== sv/tfd_checker.sv =====
// ----------------------------------------------------------------------------
// tfd_checker
// Port-level checks of the deframer output stream, bound to the top level.
// ----------------------------------------------------------------------------
module tfd_checker import tfd_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // no record once reset has been seen at an edge
  a_rst_quiet: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("output valid during reset");

  // a stalled record holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output record changed under stall");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[53:47] <= 7'd100)
    else $error("battery percent above 100");

  // km/h follows speed: zero speed gives zero, full scale stays bounded
  a_kmh_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[15:0] == 16'd0) |-> m_axis_tdata[30:16] == 15'd0)
    else $error("nonzero km/h for zero speed");

  a_kmh_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[30:16] <= 15'd30199)
    else $error("km/h above full scale");

endmodule

bind telemetry_frame_deframer tfd_checker u_tfd_checker (.*);
